[rtl/sorted_interval_overlap_filter_top_defines.svh]
// Assertion macros for the sorted interval overlap filter.
// Included by the top level; no other dependencies.
`ifndef SORTED_INTERVAL_OVERLAP_FILTER_TOP_DEFINES_SVH
`define SORTED_INTERVAL_OVERLAP_FILTER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define SIOF_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("siof assertion failed");
`define SIOF_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("siof implication failed");
`else
`define SIOF_ASSERT(lbl, cond)
`define SIOF_ASSERT_IMPL(lbl, ante, cons)
`endif

`endif

[rtl/siof_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the sorted interval overlap filter.
// No dependencies.
package siof_pkg;

    localparam int DEF_MAX_REGIONS = 1024;
    localparam int MAX_CHROMS      = 1024;

    localparam int REQ_W   = 2;
    localparam int CHROM_W = 10;
    localparam int POS_W   = 32;
    localparam int CELL_W  = 32;

    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 96;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR = 2'd0,
        REQ_LOAD  = 2'd1,
        REQ_BEGIN = 2'd2,
        REQ_FRAG  = 2'd3
    } t_req;

    typedef struct packed {
        logic [CHROM_W-1:0] chrom;
        logic [POS_W-1:0]   start_pos;
        logic [POS_W-1:0]   end_pos;
    } t_region;

    localparam int REGION_W = $bits(t_region);

endpackage

[rtl/siof_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module siof_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/sorted_interval_overlap_filter_top.sv]
`timescale 1ns / 1ps
// Channel   Dir  Payload
// s_axis    in   tuser: req_type; tdata: chrom, pos_start, pos_end, cell_id
// m_axis    out  tdata: out_start, out_end, out_cell
// cfg       in   i_cfg_we / i_cfg_wdata: invert_mode
//
// Clear and load are done in the idle state. A fragment goes straight to a compare and
// adds a read state for every region it skips, since each region compare waits on one
// read of the region RAM. A chromosome begin reads and compares each region in turn
// from index 0, with one more read state when the scan runs off the end of the table.
// Reset is synchronous and leaves the region table empty; no RAM sweep is needed.
// A result that finds the output register full waits, and no item is taken meanwhile.
// Depends on siof_pkg, siof_ram and sorted_interval_overlap_filter_top_defines.svh.
`include "sorted_interval_overlap_filter_top_defines.svh"

module sorted_interval_overlap_filter_top #(
    parameter int MAX_REGIONS = siof_pkg::DEF_MAX_REGIONS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [9:0] chrom, [41:10] pos_start, [73:42] pos_end, [105:74] cell_id
    input  logic [siof_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] req_type
    input  logic [siof_pkg::REQ_W-1:0]      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [31:0] out_start, [63:32] out_end, [95:64] out_cell
    output logic [siof_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_wdata
);
    import siof_pkg::*;

    localparam int IW = $clog2(MAX_REGIONS);
    localparam int CW = $clog2(MAX_REGIONS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_FRAG_RD,
        S_FRAG_CMP,
        S_OUT_WAIT
    } t_state;

    t_state               r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_active, n_active;
    logic [CHROM_W-1:0]   r_cur, n_cur;
    logic                 r_invert;
    logic                 r_m_valid, n_m_valid;
    logic [M_TDATA_W-1:0] r_m_data, n_m_data;
    logic [CHROM_W-1:0]   r_last_chrom, n_last_chrom;
    logic [POS_W-1:0]     r_last_start, n_last_start;
    logic [POS_W-1:0]     r_last_end, n_last_end;
    logic [POS_W-1:0]     r_start, r_end;
    logic [CELL_W-1:0]    r_cell;

    t_req               in_req;
    logic [CHROM_W-1:0] in_chrom;
    logic [POS_W-1:0]   in_start, in_end;
    logic [CELL_W-1:0]  in_cell;
    logic               in_fire;

    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    t_region           ram_wdata;
    logic [REGION_W-1:0] ram_rdata;
    t_region           rd_q;

    logic on_cur, skip, overlap, found, ld_ok, merge, emit;

    assign in_req   = t_req'(s_axis_tuser);
    assign in_chrom = s_axis_tdata[CHROM_W-1:0];
    assign in_start = s_axis_tdata[CHROM_W+POS_W-1:CHROM_W];
    assign in_end   = s_axis_tdata[CHROM_W+2*POS_W-1:CHROM_W+POS_W];
    assign in_cell  = s_axis_tdata[CHROM_W+2*POS_W+CELL_W-1:CHROM_W+2*POS_W];

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    siof_ram #(
        .WIDTH(REGION_W),
        .DEPTH(MAX_REGIONS)
    ) u_region_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(r_active[IW-1:0]),
        .o_rdata(ram_rdata)
    );

    assign rd_q = t_region'(ram_rdata);

    // The RAM always reads the active entry, so its data is ready in the cycle
    // after the active index settles.
    assign on_cur  = (r_active < r_count) && (rd_q.chrom == r_cur);
    assign skip    = on_cur && (r_start >= rd_q.start_pos) && (r_start >= rd_q.end_pos);
    assign overlap = on_cur && ((r_start < rd_q.start_pos) ? (r_end > rd_q.start_pos) : 1'b1);
    assign found   = (r_cur < rd_q.chrom) ||
                     ((r_cur == rd_q.chrom) && (r_start < rd_q.end_pos));

    assign ld_ok = (32'(in_chrom) < 32'(MAX_CHROMS));
    assign merge = (r_count != '0) && (r_last_chrom == in_chrom) && (r_last_end >= in_start);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_active     = r_active;
        n_cur        = r_cur;
        n_last_chrom = r_last_chrom;
        n_last_start = r_last_start;
        n_last_end   = r_last_end;
        ram_we       = 1'b0;
        ram_waddr    = r_count[IW-1:0];
        ram_wdata    = '{chrom: in_chrom, start_pos: in_start, end_pos: in_end};
        emit         = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    case (in_req)
                        REQ_CLEAR: begin
                            n_count  = '0;
                            n_active = '0;
                        end
                        REQ_LOAD: begin
                            if (ld_ok) begin
                                if (merge) begin
                                    if (in_end > r_last_end) begin
                                        ram_we     = 1'b1;
                                        ram_waddr  = IW'(r_count - CW'(1));
                                        ram_wdata  = '{chrom: r_last_chrom,
                                                       start_pos: r_last_start,
                                                       end_pos: in_end};
                                        n_last_end = in_end;
                                    end
                                end else if (r_count < CW'(MAX_REGIONS)) begin
                                    ram_we       = 1'b1;
                                    n_last_chrom = in_chrom;
                                    n_last_start = in_start;
                                    n_last_end   = in_end;
                                    n_count      = r_count + CW'(1);
                                end
                            end
                        end
                        REQ_BEGIN: begin
                            n_cur    = in_chrom;
                            n_active = '0;
                            n_state  = S_SRCH_RD;
                        end
                        REQ_FRAG: begin
                            n_state = S_FRAG_CMP;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SRCH_RD: begin
                n_state = (r_active < r_count) ? S_SRCH_CMP : S_IDLE;
            end
            S_SRCH_CMP: begin
                if (found) begin
                    n_state = S_IDLE;
                end else begin
                    n_active = r_active + CW'(1);
                    n_state  = S_SRCH_RD;
                end
            end
            S_FRAG_RD: begin
                n_state = S_FRAG_CMP;
            end
            S_FRAG_CMP: begin
                if (skip) begin
                    n_active = r_active + CW'(1);
                    n_state  = S_FRAG_RD;
                end else if (overlap ^ r_invert) begin
                    emit = 1'b1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT_WAIT: begin
                emit = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_m_valid = r_m_valid && !m_axis_tready;
        n_m_data  = r_m_data;
        if (emit) begin
            if (!r_m_valid || m_axis_tready) begin
                n_m_valid = 1'b1;
                n_m_data  = {r_cell, r_end, r_start};
                n_state   = S_IDLE;
            end else begin
                n_state = S_OUT_WAIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_active  <= '0;
            r_cur     <= '0;
            r_invert  <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_active     <= n_active;
            r_cur        <= n_cur;
            r_m_valid    <= n_m_valid;
            r_m_data     <= n_m_data;
            r_last_chrom <= n_last_chrom;
            r_last_start <= n_last_start;
            r_last_end   <= n_last_end;
            if (in_fire) begin
                r_start <= in_start;
                r_end   <= in_end;
                r_cell  <= in_cell;
            end
            if (i_cfg_we) begin
                r_invert <= i_cfg_wdata;
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    `SIOF_ASSERT(a_active_in_table, r_active <= r_count)
    `SIOF_ASSERT(a_count_in_range, r_count <= CW'(MAX_REGIONS))
    `SIOF_ASSERT_IMPL(a_wait_means_full, r_state == S_OUT_WAIT, r_m_valid)
    `SIOF_ASSERT_IMPL(a_write_only_idle, ram_we, r_state == S_IDLE && in_fire)

endmodule
